[rtl/xor_linked_multi_list_top_macros.svh]
// Assertion macros shared by the xor linked multi list RTL.
// No dependencies; include by bare file name.
`ifndef XOR_LINKED_MULTI_LIST_TOP_MACROS_SVH
`define XOR_LINKED_MULTI_LIST_TOP_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define XLL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define XLL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Invariant that holds at every edge.
`define XLL_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  `XLL_ASSERT_IMP(lbl, clk, rst_n, 1'b1, cond, msg)

`endif

[rtl/xll_pkg.sv]
// Shared constants, types and helpers for the xor linked multi list.
// No dependencies.
package xll_pkg;

  localparam int NODES      = 64;
  localparam int LISTS      = 16;
  localparam int VALUE_BITS = 32;

  localparam int IDX_W   = 7;                // node number 0..NODES, 0 means none
  localparam int NODE_AW = $clog2(NODES);    // node store address
  localparam int LIST_W  = 4;
  localparam int LIST_AW = $clog2(LISTS);
  localparam int LEN_W   = 7;
  localparam int CNT_W   = 7;
  localparam int OUT_W   = 32;

  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);

  localparam logic [1:0] ACT_PUSH    = 2'd0;
  localparam logic [1:0] ACT_POP     = 2'd1;
  localparam logic [1:0] ACT_MIGRATE = 2'd2;
  localparam logic [1:0] ACT_DUMP    = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;
  localparam logic [1:0] STAT_SAME  = 2'd3;

  typedef enum logic [2:0] {
    KIND_PUSH,
    KIND_POP,
    KIND_MIGRATE,
    KIND_DUMP,
    KIND_SAME
  } xll_kind_e;

  typedef struct packed {
    xll_kind_e              kind;
    logic [LIST_AW-1:0]     list_a;
    logic [LIST_AW-1:0]     list_b;
    logic [VALUE_BITS-1:0]  value;
  } xll_cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] head;
    logic [IDX_W-1:0] tail;
    logic [LEN_W-1:0] len;
  } xll_lent_t;

  localparam int LENT_W = $bits(xll_lent_t);

  typedef struct packed {
    logic [OUT_W-1:0] out_value;
    logic [1:0]       status;
    logic             last;
  } xll_res_t;

  function automatic logic node_ok(logic [IDX_W-1:0] n);
    return (n != '0) && (n <= IDX_W'(NODES));
  endfunction

  function automatic logic [NODE_AW-1:0] node_addr(logic [IDX_W-1:0] n);
    logic [IDX_W-1:0] d;
    d = n - IDX_W'(1);
    return d[NODE_AW-1:0];
  endfunction

endpackage

[rtl/xll_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module xll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns the old word on a same-address write; data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/xll_front.sv]
// Front end: accepts requests, decodes and classifies them, and queues them for the back end.
// Depends on xll_pkg.
module xll_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        action_i,
  input  logic [3:0]        list_a_i,
  input  logic [3:0]        list_b_i,
  input  logic signed [31:0] value_i,
  output logic              cmd_valid_o,
  output xll_pkg::xll_cmd_t cmd_o,
  input  logic              cmd_take_i
);

  xll_pkg::xll_cmd_t cls;
  xll_pkg::xll_cmd_t buf_q [2];
  logic              wptr_q, rptr_q;
  logic [1:0]        cnt_q;
  logic              acc, take;

  always_comb begin
    cls.list_a = xll_pkg::LIST_AW'(list_a_i % xll_pkg::LISTS);
    cls.list_b = xll_pkg::LIST_AW'(list_b_i % xll_pkg::LISTS);
    cls.value  = xll_pkg::VALUE_BITS'(unsigned'(value_i));
    case (action_i)
      xll_pkg::ACT_PUSH:    cls.kind = xll_pkg::KIND_PUSH;
      xll_pkg::ACT_POP:     cls.kind = xll_pkg::KIND_POP;
      xll_pkg::ACT_MIGRATE: cls.kind = (cls.list_a == cls.list_b) ? xll_pkg::KIND_SAME
                                                                   : xll_pkg::KIND_MIGRATE;
      xll_pkg::ACT_DUMP:    cls.kind = xll_pkg::KIND_DUMP;
      default:              cls.kind = xll_pkg::KIND_DUMP;
    endcase
  end

  assign full        = (cnt_q == 2'd2);
  assign acc         = push && !full;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign take        = cmd_take_i && cmd_valid_o;
  assign cmd_o       = buf_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (acc) begin
      buf_q[wptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (acc)  wptr_q <= !wptr_q;
      if (take) rptr_q <= !rptr_q;
      cnt_q <= cnt_q + {1'b0, acc} - {1'b0, take};
    end
  end

endmodule

[rtl/xll_rfifo.sv]
// Result queue between the back end and the result ports.
// Depends on xll_pkg.
module xll_rfifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  xll_pkg::xll_res_t res_i,
  output logic              full_o,
  output logic              empty,
  input  logic              pop,
  output xll_pkg::xll_res_t res_o
);

  xll_pkg::xll_res_t       buf_q [xll_pkg::RQ_DEPTH];
  logic [xll_pkg::RQ_AW-1:0] wptr_q, rptr_q;
  logic [xll_pkg::RQ_AW:0]   cnt_q;
  logic                      wr, rd;

  assign full_o = (cnt_q == (xll_pkg::RQ_AW+1)'(xll_pkg::RQ_DEPTH));
  assign empty  = (cnt_q == '0);
  assign wr     = push_i && !full_o;
  assign rd     = pop && !empty;
  assign res_o  = buf_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr) begin
      buf_q[wptr_q] <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr) wptr_q <= wptr_q + 1'b1;
      if (rd) rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_q + (xll_pkg::RQ_AW+1)'(wr) - (xll_pkg::RQ_AW+1)'(rd);
    end
  end

endmodule

[rtl/xll_back.sv]
// Back end: sequencer that carries out list requests on the node, list and free-stack RAMs.
// Depends on xll_pkg, xll_ram and the assertion macro header.
`include "xor_linked_multi_list_top_macros.svh"

module xll_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  xll_pkg::xll_cmd_t cmd_i,
  output logic              cmd_take_o,
  input  logic              rq_full_i,
  output logic              rq_push_o,
  output xll_pkg::xll_res_t rq_res_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LA    = 4'd1;
  localparam logic [3:0] S_PUSH1 = 4'd2;
  localparam logic [3:0] S_PUSH2 = 4'd3;
  localparam logic [3:0] S_PUSH3 = 4'd4;
  localparam logic [3:0] S_POP1  = 4'd5;
  localparam logic [3:0] S_POP2  = 4'd6;
  localparam logic [3:0] S_LB    = 4'd7;
  localparam logic [3:0] S_MG1   = 4'd8;
  localparam logic [3:0] S_MG2   = 4'd9;
  localparam logic [3:0] S_CLRA  = 4'd10;
  localparam logic [3:0] S_DW    = 4'd11;

  localparam int IW = xll_pkg::IDX_W;
  localparam int AW = xll_pkg::NODE_AW;
  localparam int LW = xll_pkg::LIST_AW;

  localparam logic [xll_pkg::LEN_W-1:0] LEN1    = xll_pkg::LEN_W'(1);
  localparam logic [xll_pkg::CNT_W-1:0] NODES_C = xll_pkg::CNT_W'(xll_pkg::NODES);

  logic [3:0]            state_q, state_d;
  xll_pkg::xll_cmd_t     cmd_q, cmd_d;
  xll_pkg::xll_lent_t    la_q, la_d, lb_q, lb_d;
  logic [IW-1:0]         node_q, node_d, aux_q, aux_d;
  logic [IW-1:0]         cur_q, cur_d, prev_q, prev_d;
  logic [xll_pkg::CNT_W-1:0] k_q, k_d, free_cnt_q, free_cnt_d;
  logic [xll_pkg::NODES-1:0] fvld_q;
  logic [xll_pkg::LISTS-1:0] lvld_q;
  logic                  lrd_vld_q, lrd_vld_d, frd_vld_q, frd_vld_d;
  logic [IW-1:0]         frd_rst_q, frd_rst_d;

  // RAM ports
  logic                  lram_we, lram_re;
  logic [LW-1:0]         lram_waddr, lram_raddr;
  logic [xll_pkg::LENT_W-1:0] lram_wdata, lram_rdata;
  logic                  kram_we, kram_re;
  logic [AW-1:0]         kram_waddr, kram_raddr;
  logic [IW-1:0]         kram_wdata, kram_rdata;
  logic                  vram_we, vram_re;
  logic [AW-1:0]         vram_waddr, vram_raddr;
  logic [xll_pkg::VALUE_BITS-1:0] vram_wdata, vram_rdata;
  logic                  fram_we, fram_re;
  logic [AW-1:0]         fram_waddr, fram_raddr;
  logic [IW-1:0]         fram_wdata, fram_rdata;

  logic                  advance;
  xll_pkg::xll_lent_t    lrd;
  logic [IW-1:0]         n_new, st, dt, nx, pn;
  logic [AW-1:0]         ftop;
  logic                  walk_end;
  logic                  take_work;

  xll_ram #(.WIDTH(xll_pkg::LENT_W), .DEPTH(xll_pkg::LISTS)) u_lram (
    .clk_i, .we_i(lram_we), .waddr_i(lram_waddr), .wdata_i(lram_wdata),
    .re_i(lram_re), .raddr_i(lram_raddr), .rdata_o(lram_rdata)
  );
  xll_ram #(.WIDTH(IW), .DEPTH(xll_pkg::NODES)) u_kram (
    .clk_i, .we_i(kram_we), .waddr_i(kram_waddr), .wdata_i(kram_wdata),
    .re_i(kram_re), .raddr_i(kram_raddr), .rdata_o(kram_rdata)
  );
  xll_ram #(.WIDTH(xll_pkg::VALUE_BITS), .DEPTH(xll_pkg::NODES)) u_vram (
    .clk_i, .we_i(vram_we), .waddr_i(vram_waddr), .wdata_i(vram_wdata),
    .re_i(vram_re), .raddr_i(vram_raddr), .rdata_o(vram_rdata)
  );
  xll_ram #(.WIDTH(IW), .DEPTH(xll_pkg::NODES)) u_fram (
    .clk_i, .we_i(fram_we), .waddr_i(fram_waddr), .wdata_i(fram_wdata),
    .re_i(fram_re), .raddr_i(fram_raddr), .rdata_o(fram_rdata)
  );

  assign advance  = !rq_full_i;
  assign lrd      = lrd_vld_q ? xll_pkg::xll_lent_t'(lram_rdata) : '0;
  assign n_new    = frd_vld_q ? fram_rdata : frd_rst_q;
  assign st       = xll_pkg::node_ok(la_q.tail) ? la_q.tail : '0;
  assign dt       = xll_pkg::node_ok(lb_q.tail) ? lb_q.tail : '0;
  assign nx       = kram_rdata ^ prev_q;
  assign pn       = xll_pkg::node_ok(kram_rdata) ? kram_rdata : '0;
  assign ftop     = xll_pkg::CNT_W'(free_cnt_q - 1'b1) <= '0 ? '0 : AW'(free_cnt_q - 1'b1);
  assign walk_end = !xll_pkg::node_ok(nx) || (k_q == xll_pkg::CNT_W'(xll_pkg::NODES - 1));
  assign take_work = cmd_take_o && (cmd_i.kind != xll_pkg::KIND_SAME);

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    la_d       = la_q;
    lb_d       = lb_q;
    node_d     = node_q;
    aux_d      = aux_q;
    cur_d      = cur_q;
    prev_d     = prev_q;
    k_d        = k_q;
    free_cnt_d = free_cnt_q;
    lrd_vld_d  = lrd_vld_q;
    frd_vld_d  = frd_vld_q;
    frd_rst_d  = frd_rst_q;
    cmd_take_o = 1'b0;
    rq_push_o  = 1'b0;
    rq_res_o   = '0;
    lram_we = 1'b0; lram_waddr = '0; lram_wdata = '0; lram_re = 1'b0; lram_raddr = '0;
    kram_we = 1'b0; kram_waddr = '0; kram_wdata = '0; kram_re = 1'b0; kram_raddr = '0;
    vram_we = 1'b0; vram_waddr = '0; vram_wdata = '0; vram_re = 1'b0; vram_raddr = '0;
    fram_we = 1'b0; fram_waddr = '0; fram_wdata = '0; fram_re = 1'b0; fram_raddr = '0;

    if (advance) begin
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_take_o = 1'b1;
            cmd_d      = cmd_i;
            if (cmd_i.kind == xll_pkg::KIND_SAME) begin
              rq_push_o = 1'b1;
              rq_res_o  = '{out_value: '0, status: xll_pkg::STAT_SAME, last: 1'b1};
            end else begin
              lram_re    = 1'b1;
              lram_raddr = cmd_i.list_a;
              lrd_vld_d  = lvld_q[cmd_i.list_a];
              state_d    = S_LA;
            end
          end
        end
        S_LA: begin
          la_d    = lrd;
          state_d = S_IDLE;
          case (cmd_q.kind)
            xll_pkg::KIND_PUSH: begin
              if (free_cnt_q == '0 || free_cnt_q > xll_pkg::CNT_W'(xll_pkg::NODES)) begin
                rq_push_o = 1'b1;
                rq_res_o  = '{out_value: '0, status: xll_pkg::STAT_FULL, last: 1'b1};
              end else begin
                fram_re    = 1'b1;
                fram_raddr = ftop;
                frd_vld_d  = fvld_q[ftop];
                frd_rst_d  = IW'(xll_pkg::NODES) - IW'(ftop);
                state_d    = S_PUSH1;
              end
            end
            xll_pkg::KIND_POP: begin
              if (lrd.len == '0 || !xll_pkg::node_ok(lrd.tail)) begin
                rq_push_o = 1'b1;
                rq_res_o  = '{out_value: '0, status: xll_pkg::STAT_EMPTY, last: 1'b1};
              end else begin
                vram_re    = 1'b1;
                vram_raddr = xll_pkg::node_addr(lrd.tail);
                kram_re    = 1'b1;
                kram_raddr = xll_pkg::node_addr(lrd.tail);
                state_d    = S_POP1;
              end
            end
            xll_pkg::KIND_MIGRATE: begin
              if (lrd.len == '0) begin
                rq_push_o = 1'b1;
                rq_res_o  = '{out_value: '0, status: xll_pkg::STAT_EMPTY, last: 1'b1};
              end else begin
                lram_re    = 1'b1;
                lram_raddr = cmd_q.list_b;
                lrd_vld_d  = lvld_q[cmd_q.list_b];
                state_d    = S_LB;
              end
            end
            xll_pkg::KIND_DUMP: begin
              if (lrd.len == '0 || !xll_pkg::node_ok(lrd.head)) begin
                rq_push_o = 1'b1;
                rq_res_o  = '{out_value: '0, status: xll_pkg::STAT_EMPTY, last: 1'b1};
              end else begin
                cur_d      = lrd.head;
                prev_d     = '0;
                k_d        = '0;
                vram_re    = 1'b1;
                vram_raddr = xll_pkg::node_addr(lrd.head);
                kram_re    = 1'b1;
                kram_raddr = xll_pkg::node_addr(lrd.head);
                state_d    = S_DW;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
        S_PUSH1: begin
          node_d     = n_new;
          free_cnt_d = free_cnt_q - 1'b1;
          vram_we    = 1'b1;
          vram_waddr = xll_pkg::node_addr(n_new);
          vram_wdata = cmd_q.value;
          if (la_q.len == '0 || !xll_pkg::node_ok(la_q.tail)) begin
            // first node of the list: no neighbors
            kram_we    = 1'b1;
            kram_waddr = xll_pkg::node_addr(n_new);
            kram_wdata = '0;
            lram_we    = 1'b1;
            lram_waddr = cmd_q.list_a;
            lram_wdata = {n_new, n_new, la_q.len + 1'b1};
            rq_push_o  = 1'b1;
            rq_res_o   = '{out_value: '0, status: xll_pkg::STAT_OK, last: 1'b1};
            state_d    = S_IDLE;
          end else begin
            kram_re    = 1'b1;
            kram_raddr = xll_pkg::node_addr(la_q.tail);
            state_d    = S_PUSH2;
          end
        end
        S_PUSH2: begin
          kram_we    = 1'b1;
          kram_waddr = xll_pkg::node_addr(la_q.tail);
          kram_wdata = kram_rdata ^ node_q;
          state_d    = S_PUSH3;
        end
        S_PUSH3: begin
          kram_we    = 1'b1;
          kram_waddr = xll_pkg::node_addr(node_q);
          kram_wdata = la_q.tail;
          lram_we    = 1'b1;
          lram_waddr = cmd_q.list_a;
          lram_wdata = {la_q.head, node_q, la_q.len + 1'b1};
          rq_push_o  = 1'b1;
          rq_res_o   = '{out_value: '0, status: xll_pkg::STAT_OK, last: 1'b1};
          state_d    = S_IDLE;
        end
        S_POP1, S_POP2: begin
          aux_d   = pn;
          state_d = S_IDLE;
          if (state_q == S_POP1 && la_q.len != LEN1 && pn != '0) begin
            // unlink the tail from its predecessor first
            kram_re    = 1'b1;
            kram_raddr = xll_pkg::node_addr(pn);
            state_d    = S_POP2;
          end else begin
            lram_we    = 1'b1;
            lram_waddr = cmd_q.list_a;
            if (la_q.len == LEN1) begin
              lram_wdata = '0;
            end else if (state_q == S_POP2) begin
              aux_d      = aux_q;
              kram_we    = 1'b1;
              kram_waddr = xll_pkg::node_addr(aux_q);
              kram_wdata = kram_rdata ^ la_q.tail;
              lram_wdata = {la_q.head, aux_q, la_q.len - 1'b1};
            end else begin
              lram_wdata = {la_q.head, {IW{1'b0}}, la_q.len - 1'b1};
            end
            // return the node to the free stack
            if (free_cnt_q < xll_pkg::CNT_W'(xll_pkg::NODES)) begin
              fram_we    = 1'b1;
              fram_waddr = AW'(free_cnt_q);
              fram_wdata = la_q.tail;
              free_cnt_d = free_cnt_q + 1'b1;
            end
            rq_push_o = 1'b1;
            rq_res_o  = '{out_value: xll_pkg::OUT_W'(vram_rdata),
                          status: xll_pkg::STAT_OK, last: 1'b1};
          end
        end
        S_LB: begin
          lb_d = lrd;
          if (lrd.len == '0) begin
            lram_we    = 1'b1;
            lram_waddr = cmd_q.list_b;
            lram_wdata = {la_q.tail, la_q.head, la_q.len};
            state_d    = S_CLRA;
          end else begin
            kram_re    = 1'b1;
            kram_raddr = xll_pkg::node_addr(xll_pkg::node_ok(lrd.tail) ? lrd.tail : '0);
            state_d    = S_MG1;
          end
        end
        S_MG1: begin
          if (dt != '0) begin
            kram_we    = 1'b1;
            kram_waddr = xll_pkg::node_addr(dt);
            kram_wdata = kram_rdata ^ st;
          end
          kram_re    = 1'b1;
          kram_raddr = xll_pkg::node_addr(st);
          state_d    = S_MG2;
        end
        S_MG2: begin
          if (st != '0) begin
            kram_we    = 1'b1;
            kram_waddr = xll_pkg::node_addr(st);
            kram_wdata = kram_rdata ^ dt;
          end
          lram_we    = 1'b1;
          lram_waddr = cmd_q.list_b;
          lram_wdata = {lb_q.head, la_q.head, lb_q.len + la_q.len};
          state_d    = S_CLRA;
        end
        S_CLRA: begin
          lram_we    = 1'b1;
          lram_waddr = cmd_q.list_a;
          lram_wdata = '0;
          rq_push_o  = 1'b1;
          rq_res_o   = '{out_value: '0, status: xll_pkg::STAT_OK, last: 1'b1};
          state_d    = S_IDLE;
        end
        S_DW: begin
          rq_push_o = 1'b1;
          rq_res_o  = '{out_value: xll_pkg::OUT_W'(vram_rdata),
                        status: xll_pkg::STAT_OK, last: walk_end};
          k_d       = k_q + 1'b1;
          if (walk_end) begin
            cur_d   = '0;
            prev_d  = '0;
            state_d = S_IDLE;
          end else begin
            // advance one node: next = link ^ previous
            prev_d     = cur_q;
            cur_d      = nx;
            vram_re    = 1'b1;
            vram_raddr = xll_pkg::node_addr(nx);
            kram_re    = 1'b1;
            kram_raddr = xll_pkg::node_addr(nx);
          end
        end
        default: state_d = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    la_q      <= la_d;
    lb_q      <= lb_d;
    node_q    <= node_d;
    aux_q     <= aux_d;
    frd_rst_q <= frd_rst_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cur_q      <= '0;
      prev_q     <= '0;
      k_q        <= '0;
      free_cnt_q <= xll_pkg::CNT_W'(xll_pkg::NODES);
      fvld_q     <= '0;
      lvld_q     <= '0;
      lrd_vld_q  <= 1'b0;
      frd_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cur_q      <= cur_d;
      prev_q     <= prev_d;
      k_q        <= k_d;
      free_cnt_q <= free_cnt_d;
      lrd_vld_q  <= lrd_vld_d;
      frd_vld_q  <= frd_vld_d;
      if (fram_we) fvld_q[fram_waddr] <= 1'b1;
      if (lram_we) lvld_q[lram_waddr] <= 1'b1;
    end
  end

  `XLL_ASSERT_ALWAYS(a_free_cnt_range, clk_i, rst_ni, free_cnt_q <= NODES_C, "free count too big")
  `XLL_ASSERT_IMP(a_no_push_when_full, clk_i, rst_ni, rq_push_o, !rq_full_i, "push into full queue")
  `XLL_ASSERT_NXT(a_take_starts_work, clk_i, rst_ni, take_work, state_q == S_LA, "list read skipped")
  `XLL_ASSERT_IMP(a_walk_bounded, clk_i, rst_ni, state_q == S_DW, k_q < NODES_C, "dump walk too long")

endmodule

[rtl/xor_linked_multi_list_top.sv]
// Top level of the xor linked multi list: request queue, sequencer and result queue.
// Depends on xll_pkg, xll_front, xll_back and xll_rfifo.

// Keeps 16 lists in a shared pool of 64 nodes; each node holds a 32-bit value and
// the XOR of its neighbors' node numbers (0 means none), and a free stack hands out
// nodes. Requests go in through push/full; action 0 appends value at the tail of
// list_a (status 2 when the pool is full), 1 removes the tail of list_a and returns
// its value (status 1 when empty), 2 appends list_a reversed onto list_b and empties
// list_a (status 1 when list_a is empty, 3 when both name the same list), 3 walks
// list_a head to tail and gives one result per element, last set on the final one.
// Every request gives exactly one result except dump, which gives one per element
// (one with status 1 for an empty list). Results come out through empty/pop in
// request order. A request is accepted while a two-entry request queue has room and
// is carried out by one sequencer at a time; the list table, link store, value store
// and free stack are single-write, single-read RAMs with registered reads, which the
// sequencer reads and writes in a chain of states. The sequencer holds while the
// four-entry result queue is full. No clearing pass is needed after reset: reset
// values come from per-entry valid bits.
module xor_linked_multi_list_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        action_i,
  input  logic [3:0]        list_a_i,
  input  logic [3:0]        list_b_i,
  input  logic signed [31:0] value_i,
  output logic              empty,
  input  logic              pop,
  output logic signed [31:0] out_value_o,
  output logic [1:0]        status_o,
  output logic              last_o
);

  logic              cmd_valid, cmd_take;
  xll_pkg::xll_cmd_t cmd;
  logic              rq_push, rq_full;
  xll_pkg::xll_res_t rq_res, res;

  // decode and queue incoming requests
  xll_front u_front (
    .clk_i, .rst_ni, .push, .full,
    .action_i, .list_a_i, .list_b_i, .value_i,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_take_i(cmd_take)
  );

  // carry out one request at a time against the RAMs
  xll_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_take_o(cmd_take),
    .rq_full_i(rq_full), .rq_push_o(rq_push), .rq_res_o(rq_res)
  );

  // hold results until the consumer pops them
  xll_rfifo u_rfifo (
    .clk_i, .rst_ni,
    .push_i(rq_push), .res_i(rq_res), .full_o(rq_full),
    .empty, .pop, .res_o(res)
  );

  assign out_value_o = signed'(res.out_value);
  assign status_o    = res.status;
  assign last_o      = res.last;

endmodule

[tb/tb_xor_linked_multi_list_top.sv]
// Testbench for xor_linked_multi_list_top: random and directed list requests are
// checked against an in-bench model of the node pool. Depends on xll_pkg and the RTL.
`timescale 1ns / 100ps

module tb_xor_linked_multi_list_top;

  typedef struct {
    logic [1:0]  action;
    logic [3:0]  list_a;
    logic [3:0]  list_b;
    logic [31:0] value;
  } list_req_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              push = 1'b0;
  logic              full;
  logic [1:0]        action_i = xll_pkg::ACT_PUSH;
  logic [3:0]        list_a_i = '0;
  logic [3:0]        list_b_i = '0;
  logic signed [31:0] value_i = '0;
  logic              empty;
  logic              pop = 1'b0;
  logic signed [31:0] out_value_o;
  logic [1:0]        status_o;
  logic              last_o;

  xor_linked_multi_list_top u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full),
    .action_i(action_i), .list_a_i(list_a_i), .list_b_i(list_b_i), .value_i(value_i),
    .empty(empty), .pop(pop), .out_value_o(out_value_o), .status_o(status_o),
    .last_o(last_o)
  );

  always #2 clk_i = ~clk_i;

  // Shadow copy of the list table, node stores and free stack.
  logic [6:0]  sh_head [16];
  logic [6:0]  sh_tail [16];
  logic [6:0]  sh_len  [16];
  logic [6:0]  sh_link [65];
  logic [31:0] sh_val  [65];
  logic [6:0]  sh_free [64];
  logic [6:0]  sh_free_cnt;

  list_req_t         req_backlog[$];   // requests waiting for the driver
  xll_pkg::xll_res_t results_due[$];   // results owed by the block, oldest first
  list_req_t         req_on_bus;
  int          errors = 0;
  int          reqs_taken = 0;
  int          results_seen = 0;
  int          full_hits = 0;
  int          send_gap = 0;
  int          recv_gap = 0;
  bit          steady = 1'b0;

  function automatic xll_pkg::xll_res_t mk_res(logic [31:0] v, logic [1:0] st, logic lst);
    xll_pkg::xll_res_t r;
    r.out_value = v;
    r.status    = st;
    r.last      = lst;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Apply one request to the shadow pool and queue the results it owes.
  task automatic pool_apply(input list_req_t rq);
    logic [3:0] a, b;
    logic [6:0] n, t, p, st, dt, cur, prv, nx;
    int         k;
    a = rq.list_a;
    b = rq.list_b;
    case (rq.action)
      xll_pkg::ACT_PUSH: begin
        if (sh_free_cnt == 0) begin
          full_hits++;
          results_due.push_back(mk_res('0, xll_pkg::STAT_FULL, 1'b1));
        end else begin
          sh_free_cnt--;
          n = sh_free[sh_free_cnt];
          sh_val[n] = rq.value;
          t = sh_tail[a];
          if (sh_len[a] == 0) begin
            sh_link[n] = '0;
            sh_head[a] = n;
          end else begin
            sh_link[t] = sh_link[t] ^ n;
            sh_link[n] = t;
          end
          sh_tail[a] = n;
          sh_len[a]++;
          results_due.push_back(mk_res('0, xll_pkg::STAT_OK, 1'b1));
        end
      end
      xll_pkg::ACT_POP: begin
        if (sh_len[a] == 0) begin
          results_due.push_back(mk_res('0, xll_pkg::STAT_EMPTY, 1'b1));
        end else begin
          t = sh_tail[a];
          if (sh_len[a] == 1) begin
            sh_head[a] = '0;
            sh_tail[a] = '0;
          end else begin
            p = sh_link[t];
            sh_link[p] = sh_link[p] ^ t;
            sh_tail[a] = p;
          end
          sh_len[a]--;
          sh_free[sh_free_cnt] = t;
          sh_free_cnt++;
          results_due.push_back(mk_res(sh_val[t], xll_pkg::STAT_OK, 1'b1));
        end
      end
      xll_pkg::ACT_MIGRATE: begin
        if (a == b) begin
          results_due.push_back(mk_res('0, xll_pkg::STAT_SAME, 1'b1));
        end else if (sh_len[a] == 0) begin
          results_due.push_back(mk_res('0, xll_pkg::STAT_EMPTY, 1'b1));
        end else begin
          if (sh_len[b] == 0) begin
            sh_head[b] = sh_tail[a];
            sh_tail[b] = sh_head[a];
            sh_len[b]  = sh_len[a];
          end else begin
            st = sh_tail[a];
            dt = sh_tail[b];
            sh_link[dt] = sh_link[dt] ^ st;
            sh_link[st] = sh_link[st] ^ dt;
            sh_tail[b]  = sh_head[a];
            sh_len[b]   = sh_len[b] + sh_len[a];
          end
          sh_head[a] = '0;
          sh_tail[a] = '0;
          sh_len[a]  = '0;
          results_due.push_back(mk_res('0, xll_pkg::STAT_OK, 1'b1));
        end
      end
      default: begin
        k = 0;
        prv = '0;
        cur = (sh_len[a] == 0) ? 7'd0 : sh_head[a];
        while (cur != 0 && cur <= 64 && k < 64) begin
          results_due.push_back(mk_res(sh_val[cur], xll_pkg::STAT_OK, 1'b0));
          k++;
          nx  = sh_link[cur] ^ prv;
          prv = cur;
          cur = nx;
        end
        if (k == 0) results_due.push_back(mk_res('0, xll_pkg::STAT_EMPTY, 1'b1));
        else results_due[$].last = 1'b1;
      end
    endcase
  endtask

  function automatic list_req_t mk_req(logic [1:0] act, logic [3:0] la, logic [3:0] lb,
                                       logic [31:0] v);
    list_req_t r;
    r.action = act;
    r.list_a = la;
    r.list_b = lb;
    r.value  = v;
    return r;
  endfunction

  // Pick a list: mostly a few busy ones so lists grow long, sometimes any.
  function automatic logic [3:0] pick_list();
    if ($urandom_range(0, 3) != 0) return 4'($urandom_range(0, 3));
    return 4'($urandom_range(0, 15));
  endfunction

  // Driver: hand the next pending request to the block, with random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        pool_apply(req_on_bus);
        reqs_taken++;
      end
      if ($urandom_range(0, 199) == 0) steady = ~steady;
      if (!push || !full) begin
        if (send_gap > 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (req_backlog.size() > 0) begin
          req_on_bus = req_backlog.pop_front();
          action_i <= req_on_bus.action;
          list_a_i <= req_on_bus.list_a;
          list_b_i <= req_on_bus.list_b;
          value_i  <= req_on_bus.value;
          push     <= 1'b1;
          send_gap = steady ? 0 : pick_gap();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: take results with random stalls and compare with the oldest owed one.
  always @(posedge clk_i or negedge rst_ni) begin
    xll_pkg::xll_res_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        results_seen++;
        if (results_due.size() == 0) begin
          $error("unexpected result: out_value %0h status %0d last %0d",
                 out_value_o, status_o, last_o);
          errors++;
        end else begin
          want = results_due.pop_front();
          if (out_value_o !== want.out_value) begin
            $error("out_value: expected %0h, got %0h", want.out_value, out_value_o);
            errors++;
          end
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            errors++;
          end
          if (last_o !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last_o);
            errors++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        recv_gap = steady ? 0 : pick_gap();
      end
    end
  end

  initial begin
    int r;
    for (int i = 0; i < 16; i++) begin
      sh_head[i] = '0;
      sh_tail[i] = '0;
      sh_len[i]  = '0;
    end
    for (int i = 0; i < 65; i++) begin
      sh_link[i] = '0;
      sh_val[i]  = '0;
    end
    for (int i = 0; i < 64; i++) sh_free[i] = 7'(64 - i);
    sh_free_cnt = 7'd64;

    // Directed: value extremes, empty lists, same-list and empty-source migrates,
    // migrate onto empty and nonempty targets, dumps after each change.
    req_backlog.push_back(mk_req(xll_pkg::ACT_PUSH, 4'd0, 4'd9, 32'h8000_0000));
    req_backlog.push_back(mk_req(xll_pkg::ACT_PUSH, 4'd0, 4'd0, 32'h7fff_ffff));
    req_backlog.push_back(mk_req(xll_pkg::ACT_PUSH, 4'd0, 4'd15, 32'h0000_0000));
    req_backlog.push_back(mk_req(xll_pkg::ACT_PUSH, 4'd15, 4'd0, 32'hffff_ffff));
    req_backlog.push_back(mk_req(xll_pkg::ACT_PUSH, 4'd15, 4'd3, 32'h0000_0001));
    req_backlog.push_back(mk_req(xll_pkg::ACT_POP, 4'd5, 4'd0, 32'h0));
    req_backlog.push_back(mk_req(xll_pkg::ACT_DUMP, 4'd5, 4'd15, 32'h0));
    req_backlog.push_back(mk_req(xll_pkg::ACT_MIGRATE, 4'd5, 4'd6, 32'h0));
    req_backlog.push_back(mk_req(xll_pkg::ACT_MIGRATE, 4'd3, 4'd3, 32'h0));
    req_backlog.push_back(mk_req(xll_pkg::ACT_MIGRATE, 4'd15, 4'd15, 32'h0));
    req_backlog.push_back(mk_req(xll_pkg::ACT_DUMP, 4'd0, 4'd0, 32'h0));
    req_backlog.push_back(mk_req(xll_pkg::ACT_MIGRATE, 4'd0, 4'd15, 32'h0));
    req_backlog.push_back(mk_req(xll_pkg::ACT_DUMP, 4'd15, 4'd0, 32'h0));
    req_backlog.push_back(mk_req(xll_pkg::ACT_MIGRATE, 4'd15, 4'd7, 32'h0));
    req_backlog.push_back(mk_req(xll_pkg::ACT_DUMP, 4'd7, 4'd0, 32'h0));
    req_backlog.push_back(mk_req(xll_pkg::ACT_POP, 4'd7, 4'd0, 32'h0));
    req_backlog.push_back(mk_req(xll_pkg::ACT_POP, 4'd7, 4'd0, 32'h0));
    req_backlog.push_back(mk_req(xll_pkg::ACT_PUSH, 4'd7, 4'd0, 32'h1234_5678));
    req_backlog.push_back(mk_req(xll_pkg::ACT_DUMP, 4'd7, 4'd0, 32'h0));
    req_backlog.push_back(mk_req(xll_pkg::ACT_DUMP, 4'd15, 4'd0, 32'h0));

    // Random: pushes dominate so lists grow; one burst drains the pool to full.
    for (int i = 0; i < 20; i++) begin
      r = $urandom_range(0, 99);
      if (i == 10) begin
        for (int j = 0; j < 66; j++)
          req_backlog.push_back(mk_req(xll_pkg::ACT_PUSH, pick_list(), 4'($urandom),
                                       $urandom));
        req_backlog.push_back(mk_req(xll_pkg::ACT_DUMP, pick_list(), 4'($urandom), $urandom));
      end else if (r < 45) begin
        req_backlog.push_back(mk_req(xll_pkg::ACT_PUSH, pick_list(), 4'($urandom), $urandom));
      end else if (r < 65) begin
        req_backlog.push_back(mk_req(xll_pkg::ACT_POP, pick_list(), 4'($urandom), $urandom));
      end else if (r < 85) begin
        req_backlog.push_back(mk_req(xll_pkg::ACT_MIGRATE, pick_list(), pick_list(),
                                     $urandom));
      end else begin
        req_backlog.push_back(mk_req(xll_pkg::ACT_DUMP, pick_list(), 4'($urandom), $urandom));
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Hold until every request is taken and every owed result has come out.
    wait (req_backlog.size() == 0 && !push && results_due.size() == 0);
    repeat (50) @(posedge clk_i);
    $display("covered %0d requests, %0d results, %0d pushes refused on a full pool",
             reqs_taken, results_seen, full_hits);
    if (errors == 0 && results_due.size() == 0) begin
      $display("tb_xor_linked_multi_list_top: clean");
    end else begin
      $display("tb_xor_linked_multi_list_top: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_xor_linked_multi_list_top: errors");
    $finish;
  end

endmodule
